// ----- hdl/string_intern_hash_table_assert.svh -----
// Assertion macros shared by the checker of the string intern table.
`ifndef STRING_INTERN_HASH_TABLE_ASSERT_SVH
`define STRING_INTERN_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SITH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sith check failed");

// Next-cycle implication, disabled during reset.
`define SITH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sith check failed");

`endif

// ----- hdl/sith_pkg.sv -----
// Types, constants and the hash step of the string intern table.
`timescale 1ns / 1ps
package sith_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int MAX_NAME_DEF = 16;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [9:0] symbol_slot;
      logic       is_new;
      logic [1:0] status;
   } rsp_type;

   // One FNV-1a step; the prime is 2^40 + 2^8 + 0xB3.
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x * 64'd179);
   endfunction

endpackage

// ----- hdl/sith_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module sith_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/sith_mod.sv -----
// Radix-16 remainder of a 64-bit hash by the table capacity.
`timescale 1ns / 1ps
module sith_mod #(
   parameter int CAPACITY = sith_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [63:0]                 dividend,
   output logic                        done,
   output logic [$clog2(CAPACITY)-1:0] remainder
);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int V_W   = IDX_W + 4;

   logic [63:0]      dvd_ff, dvd_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [V_W-1:0]   val;
   logic [V_W-1:0]   sub;

   // one hex digit per cycle: largest constant multiple not above the value
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      val     = {rem_ff, dvd_ff[63:60]};
      sub     = '0;
      for (int k = 1; k < 16; k++) begin
         if (val >= V_W'(k * CAPACITY)) begin
            sub = V_W'(k * CAPACITY);
         end
      end
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = IDX_W'(val - sub);
         dvd_in = {dvd_ff[59:0], 4'd0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

// ----- hdl/string_intern_hash_table.sv -----
// Top level of the string intern table: FNV-1a hashing and linear-probe lookup.
`timescale 1ns / 1ps
//  channel  dir  handshake            word
//  req      in   req_valid/req_stall  name_byte, last_byte
//  rsp      out  rsp_valid/rsp_stall  symbol_slot, is_new, status
//
//  A non-final byte keeps ST_IDLE. A final byte holds the input while the
//  hash remainder runs 16 radix-16 digit steps in ST_MOD, then each probe
//  reads the meta and name RAMs (ST_RD) and compares (ST_CMP), and ST_RESP
//  loads the answer. Over-long names go from the final byte to ST_RESP.
//  After reset a clearing pass over all CAPACITY slots wipes the slot
//  metadata RAM; no byte is taken meanwhile.
//  rsp_stall only holds the answer; bytes of the next name are taken while
//  it waits, the next name's answer waits in ST_RESP for the register to free.
module string_intern_hash_table #(
   parameter int CAPACITY = sith_pkg::CAPACITY_DEF,
   parameter int MAX_NAME = sith_pkg::MAX_NAME_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sith_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sith_pkg::rsp_type rsp_data
);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int LEN_W  = $clog2(MAX_NAME + 1);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int NAME_W = MAX_NAME * 8;
   localparam int META_W = LEN_W + 1;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_MOD   = 6'b000100,
      ST_RD    = 6'b001000,
      ST_CMP   = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [63:0]       hash_ff, hash_in;
   logic [NAME_W-1:0] pend_name_ff, pend_name_in;
   logic [LEN_W-1:0]  pend_len_ff, pend_len_in;
   logic              pend_ovf_ff, pend_ovf_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [IDX_W:0]    walked_ff, walked_in;
   sith_pkg::rsp_type res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sith_pkg::rsp_type rsp_ff, rsp_in;

   // Hash remainder unit
   logic             mod_start, mod_done;
   logic [IDX_W-1:0] mod_rem;

   // RAM ports
   logic              meta_we, ram_re;
   logic [IDX_W-1:0]  meta_waddr;
   logic [META_W-1:0] meta_wdata, meta_rdata;
   logic              name_we;
   logic [NAME_W-1:0] name_rdata;

   logic              accept, ovf_next, mismatch, full;
   logic [CNT_W+1:0]  need;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign ovf_next  = pend_ovf_ff || (pend_len_ff == LEN_W'(MAX_NAME));
   assign mod_start = accept && req_data.last_byte && !ovf_next;

   // occupancy limit: (entries + 1) * 2 must not exceed the capacity
   assign need = ((CNT_W+2)'(count_ff) + (CNT_W+2)'(1)) << 1;
   assign full = need > (CNT_W+2)'(CAPACITY);

   // stored name against pending name over the pending length only
   always_comb begin
      mismatch = 1'b0;
      for (int k = 0; k < MAX_NAME; k++) begin
         if ((LEN_W'(k) < pend_len_ff) &&
             (name_rdata[k*8 +: 8] != pend_name_ff[k*8 +: 8])) begin
            mismatch = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      pend_name_in = pend_name_ff;
      pend_len_in  = pend_len_ff;
      pend_ovf_in  = pend_ovf_ff;
      count_in     = count_ff;
      clr_addr_in  = clr_addr_ff;
      slot_in      = slot_ff;
      walked_in    = walked_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      meta_we      = 1'b0;
      meta_waddr   = slot_ff;
      meta_wdata   = {1'b1, pend_len_ff};
      name_we      = 1'b0;
      ram_re       = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_addr_ff;
            meta_wdata = '0;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               hash_in = sith_pkg::fnv_step(hash_ff, req_data.name_byte);
               if (pend_len_ff < LEN_W'(MAX_NAME)) begin
                  for (int k = 0; k < MAX_NAME; k++) begin
                     if (pend_len_ff == LEN_W'(k)) begin
                        pend_name_in[k*8 +: 8] = req_data.name_byte;
                     end
                  end
                  pend_len_in = pend_len_ff + LEN_W'(1);
               end else begin
                  pend_ovf_in = 1'b1;
               end
               if (req_data.last_byte) begin
                  if (ovf_next) begin
                     res_in   = '{symbol_slot: '0, is_new: 1'b0,
                                  status: sith_pkg::STATUS_TOO_LONG};
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_MOD;
                  end
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               slot_in   = mod_rem;
               walked_in = '0;
               state_in  = ST_RD;
            end
         end
         ST_RD: begin
            ram_re   = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!meta_rdata[META_W-1]) begin
               // empty slot ends the walk
               if (full) begin
                  res_in = '{symbol_slot: '0, is_new: 1'b0,
                             status: sith_pkg::STATUS_FULL};
               end else begin
                  meta_we  = 1'b1;
                  name_we  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  res_in   = '{symbol_slot: 10'(slot_ff), is_new: 1'b1,
                               status: sith_pkg::STATUS_OK};
               end
               state_in = ST_RESP;
            end else if ((meta_rdata[LEN_W-1:0] == pend_len_ff) && !mismatch) begin
               res_in   = '{symbol_slot: 10'(slot_ff), is_new: 1'b0,
                            status: sith_pkg::STATUS_OK};
               state_in = ST_RESP;
            end else if (walked_ff == (IDX_W+1)'(CAPACITY - 1)) begin
               // every slot visited
               res_in   = '{symbol_slot: '0, is_new: 1'b0,
                            status: sith_pkg::STATUS_FULL};
               state_in = ST_RESP;
            end else begin
               walked_in = walked_ff + (IDX_W+1)'(1);
               slot_in   = (slot_ff == IDX_W'(CAPACITY - 1)) ? '0 : slot_ff + IDX_W'(1);
               state_in  = ST_RD;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               hash_in      = sith_pkg::FNV_BASIS;
               pend_len_in  = '0;
               pend_ovf_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         hash_ff      <= sith_pkg::FNV_BASIS;
         pend_len_ff  <= '0;
         pend_ovf_ff  <= 1'b0;
         count_ff     <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         pend_len_ff  <= pend_len_in;
         pend_ovf_ff  <= pend_ovf_in;
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_name_ff <= pend_name_in;
      slot_ff      <= slot_in;
      walked_ff    <= walked_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   sith_mod #(.CAPACITY(CAPACITY)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (hash_in),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // slot metadata: valid mark and name length
   sith_ram #(.WIDTH(META_W), .DEPTH(CAPACITY)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (ram_re),
      .rd_addr (slot_ff),
      .rd_data (meta_rdata)
   );

   // one full name row per slot
   sith_ram #(.WIDTH(NAME_W), .DEPTH(CAPACITY)) u_name (
      .clock   (clock),
      .wr_en   (name_we),
      .wr_addr (slot_ff),
      .wr_data (pend_name_ff),
      .rd_en   (ram_re),
      .rd_addr (slot_ff),
      .rd_data (name_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- hdl/sith_checker.sv -----
// Port-level checks of the string intern table and their bind.
`timescale 1ns / 1ps
`include "string_intern_hash_table_assert.svh"
module sith_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input sith_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sith_pkg::rsp_type rsp_data
);
   logic last_acc, new_ok;

   assign last_acc = req_valid && !req_stall && req_data.last_byte;
   assign new_ok   = (rsp_data.status == sith_pkg::STATUS_OK);

   `SITH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SITH_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   `SITH_ASSERT_NOW(a_new_is_ok, clock, reset, rsp_valid && rsp_data.is_new, new_ok)
   `SITH_ASSERT_NEXT(a_last_busy, clock, reset, last_acc, req_stall)
endmodule

bind string_intern_hash_table sith_checker u_sith_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- tb/tb.sv -----
// Self-checking bench for the string intern table: directed and random byte streams against a predictor.
`timescale 1ns / 1ps
module tb;
   localparam int CAP = sith_pkg::CAPACITY_DEF;
   localparam int MAXN = sith_pkg::MAX_NAME_DEF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sith_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sith_pkg::rsp_type rsp_data;

   string_intern_hash_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // predictor state
   logic [63:0] hash_acc;
   logic [7:0]  pend_name [MAXN];
   int          pend_len;
   bit          pend_over;
   bit          tab_valid [CAP];
   int          tab_len [CAP];
   logic [7:0]  tab_name [CAP][MAXN];
   int          entries;

   sith_pkg::req_type byte_queue[$];
   sith_pkg::rsp_type answer_queue[$];
   bit      failed = 1'b0;
   bit      quiet = 1'b0;
   bit      stim_done = 1'b0;
   int      drv_gap = 0;
   int      mon_gap = 0;

   // dictionary of names used so the random part revisits existing symbols
   logic [7:0] dict_name [$][$];

   function automatic bit same_name(int s);
      if (tab_len[s] != pend_len) return 1'b0;
      for (int i = 0; i < pend_len; i++)
         if (tab_name[s][i] != pend_name[i]) return 1'b0;
      return 1'b1;
   endfunction

   // fold one accepted word into the model; queue an answer on a final byte
   task automatic intern_word(sith_pkg::req_type w);
      sith_pkg::rsp_type r;
      int      s;
      bit      done;
      hash_acc = (hash_acc ^ {56'd0, w.name_byte}) * 64'd1099511628211;
      if (pend_len < MAXN) begin
         pend_name[pend_len] = w.name_byte;
         pend_len++;
      end else begin
         pend_over = 1'b1;
      end
      if (!w.last_byte) return;
      r = '{symbol_slot: '0, is_new: 1'b0, status: sith_pkg::STATUS_FULL};
      if (pend_over) begin
         r.status = sith_pkg::STATUS_TOO_LONG;
      end else begin
         s = int'(hash_acc % CAP);
         done = 1'b0;
         for (int k = 0; k < CAP && !done; k++) begin
            if (!tab_valid[s]) begin
               done = 1'b1;
               if ((entries + 1) * 2 <= CAP) begin
                  tab_valid[s] = 1'b1;
                  tab_len[s] = pend_len;
                  for (int i = 0; i < pend_len; i++) tab_name[s][i] = pend_name[i];
                  entries++;
                  r = '{symbol_slot: 10'(s), is_new: 1'b1, status: sith_pkg::STATUS_OK};
               end
            end else if (same_name(s)) begin
               done = 1'b1;
               r = '{symbol_slot: 10'(s), is_new: 1'b0, status: sith_pkg::STATUS_OK};
            end else begin
               s = (s + 1) % CAP;
            end
         end
      end
      answer_queue.push_back(r);
      hash_acc = sith_pkg::FNV_BASIS;
      pend_len = 0;
      pend_over = 1'b0;
   endtask

   task automatic push_name(input logic [7:0] n[$]);
      sith_pkg::req_type w;
      foreach (n[i]) begin
         w.name_byte = n[i];
         w.last_byte = (i == n.size() - 1);
         byte_queue.push_back(w);
      end
   endtask

   function automatic void rand_name(output logic [7:0] n[$], input int len);
      n = {};
      for (int i = 0; i < len; i++) n.push_back(8'($urandom_range(1, 255)));
   endfunction

   initial begin
      forever #2 clock = ~clock;
   end

   // driver: holds a word until accepted, idles in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) intern_word(req_data);
         if (stim_done && byte_queue.size() < 300) quiet <= 1'b1;
         if (drv_gap > 0) begin
            drv_gap <= drv_gap - 1;
            req_valid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            req_data <= byte_queue.pop_front();
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) drv_gap <= $urandom_range(1, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: random stall bursts, compares each accepted answer
   always @(posedge clock) begin
      sith_pkg::rsp_type exp_w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_queue.size() == 0) begin
               $display("%0t unexpected answer: expected none, actual %p", $time, rsp_data);
               failed = 1'b1;
            end else begin
               exp_w = answer_queue.pop_front();
               if (rsp_data.symbol_slot !== exp_w.symbol_slot)
                  begin $display("%0t symbol_slot: expected %0d, actual %0d", $time,
                     exp_w.symbol_slot, rsp_data.symbol_slot); failed = 1'b1; end
               if (rsp_data.is_new !== exp_w.is_new)
                  begin $display("%0t is_new: expected %0d, actual %0d", $time,
                     exp_w.is_new, rsp_data.is_new); failed = 1'b1; end
               if (rsp_data.status !== exp_w.status)
                  begin $display("%0t status: expected %0d, actual %0d", $time,
                     exp_w.status, rsp_data.status); failed = 1'b1; end
            end
         end
         if (mon_gap > 0) begin
            mon_gap <= mon_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            mon_gap <= $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus
   initial begin
      logic [7:0] n[$];
      int         total;
      int         pick;
      hash_acc = sith_pkg::FNV_BASIS;
      pend_len = 0;
      pend_over = 1'b0;
      entries = 0;
      foreach (tab_valid[i]) tab_valid[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes, single bytes, repeat lookup, max and too long
      n = {8'd1};                    push_name(n); push_name(n);
      n = {8'd255};                  push_name(n);
      n = {8'h80, 8'h7F, 8'h55, 8'hAA}; push_name(n); push_name(n);
      rand_name(n, MAXN);            push_name(n); push_name(n);
      rand_name(n, MAXN + 1);        push_name(n);
      rand_name(n, 3);               push_name(n);

      // random: mostly fresh or repeated names, some too long
      total = 0;
      while (total < 1600) begin
         pick = $urandom_range(0, 9);
         if (pick < 4 && dict_name.size() > 0) begin
            n = dict_name[$urandom_range(0, dict_name.size() - 1)];
         end else if (pick == 9) begin
            rand_name(n, $urandom_range(MAXN + 1, MAXN + 4));
         end else begin
            rand_name(n, $urandom_range(1, MAXN));
            if ($urandom_range(0, 3) == 0) n[0] = 8'($urandom_range(0, 1) ? 8'd1 : 8'd255);
            dict_name.push_back(n);
         end
         push_name(n);
         total += n.size();
      end
      stim_done = 1'b1;
   end

   // finish once everything is accepted and answered
   initial begin
      wait (stim_done);
      wait (byte_queue.size() == 0 && !req_valid && answer_queue.size() == 0);
      repeat (200) @(posedge clock);
      if (!failed && answer_queue.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // timeout: fails the run if it does not finish in time
   initial begin
      #400ms;
      $display("status: fail");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/sith_pkg.sv
hdl/sith_ram.sv
hdl/sith_mod.sv
hdl/string_intern_hash_table.sv
hdl/sith_checker.sv
tb/tb.sv
